// ----- hdl/plc_pkg.sv -----
// ---------------------------------------------------------------------------
// plc_pkg: shared types and codes for the positional list engine
// Item structs, opcode and status codes, sequencer states and the control
// bundle broadcast to every list cell.
// ---------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

    // opcodes carried in an input item
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_LOCATE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // field widths fixed by the item format
    localparam int POS_W  = 9;
    localparam int DATA_W = 32;

    typedef struct packed {
        logic [2:0]              opcode;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data_out;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         length;
        logic                     is_empty;
    } rsp_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    // control broadcast to all cells
    typedef struct packed {
        logic              ins;     // insert at pos_m1, shift tail up
        logic              del;     // remove at pos_m1, shift tail down
        logic              load;    // snapshot entries into tap chain
        logic              shift;   // move tap chain one cell to the head
        logic [POS_W-1:0]  pos_m1;  // zero-based target position
        logic [POS_W-1:0]  count;   // list length before the operation
        logic [DATA_W-1:0] value;   // insert value or search key
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/positional_list_engine.sv -----
// ---------------------------------------------------------------------------
// positional_list_engine: ordered list with positional insert and delete
// Top level: sequencer, length counter, result registers and cell row.
// ---------------------------------------------------------------------------
// The list lives in a row of DEPTH cells; insert and delete shift every entry
// behind the target position in the cycle the item is accepted. Reads go
// through a tap chain that moves one cell a cycle towards cell 0 during a
// scan, so the latency depends on the position reached. Insert, clear, locate
// on an empty list and every error finish without a scan; get and delete scan
// up to the position; locate scans up to the match position, or up to the
// length when nothing matches. A finished result sits in the output register
// while the next item is taken. Entries are not cleared at reset; only the
// control registers, the length counter among them, are.
`default_nettype none

module positional_list_engine #(
    parameter int DEPTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire plc_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output plc_pkg::rsp_t      rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    // control state
    plc_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            pend_reg, pend_next;
    logic            out_valid_reg, out_valid_next;

    // payload state
    plc_pkg::rsp_t   res_reg, res_next;
    plc_pkg::rsp_t   out_reg, out_next;
    logic            scan_loc_reg, scan_loc_next;
    logic [CW-1:0]   scan_pos_reg, scan_pos_next;
    logic [CW-1:0]   scan_lim_reg, scan_lim_next;
    logic [CW-1:0]   idx_reg, idx_next;

    plc_pkg::cell_ctrl_t ctrl;

    logic [plc_pkg::DATA_W-1:0] entry_w [DEPTH];
    logic [plc_pkg::DATA_W-1:0] tap_w   [DEPTH];
    logic                       hit_w   [DEPTH];

    logic                       accept;
    logic [plc_pkg::POS_W-1:0]  cnt9;
    logic [plc_pkg::POS_W-1:0]  pos_m1;
    logic                       pos_in_list;
    logic                       pos_insertable;
    logic                       full;

    // input held off while busy or while a result waits for the output register
    assign req_stall = (state_reg != plc_pkg::S_IDLE) || pend_reg;

    assign accept = req_valid && !req_stall;
    assign cnt9   = plc_pkg::POS_W'(count_reg);
    assign pos_m1 = req.position - plc_pkg::POS_W'(1);
    assign full   = (count_reg == CW'(DEPTH));
    assign pos_in_list    = (req.position != '0) && (req.position <= cnt9);
    assign pos_insertable = (req.position != '0) && (pos_m1 <= cnt9);

    // row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [plc_pkg::DATA_W-1:0] left_e;
        logic [plc_pkg::DATA_W-1:0] right_e;
        logic [plc_pkg::DATA_W-1:0] right_t;
        logic                       right_h;

        if (i == 0)
        begin : g_head
            assign left_e = '0;
        end
        else
        begin : g_body
            assign left_e = entry_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_e = '0;
            assign right_t = '0;
            assign right_h = 1'b0;
        end
        else
        begin : g_link
            assign right_e = entry_w[i+1];
            assign right_t = tap_w[i+1];
            assign right_h = hit_w[i+1];
        end

        plc_cell #(
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .left_entry  (left_e),
            .right_entry (right_e),
            .right_tap   (right_t),
            .right_hit   (right_h),
            .entry       (entry_w[i]),
            .tap         (tap_w[i]),
            .hit         (hit_w[i])
        );
    end

    // sequencer: decode, cell control, scan and result hand-off
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        scan_loc_next  = scan_loc_reg;
        scan_pos_next  = scan_pos_reg;
        scan_lim_next  = scan_lim_reg;
        idx_next       = idx_reg;

        ctrl        = '0;
        ctrl.pos_m1 = pos_m1;
        ctrl.count  = cnt9;
        ctrl.value  = req.value;

        case (state_reg)
            plc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load               = 1'b1;
                    res_next                = '0;
                    res_next.status         = plc_pkg::ST_OK;
                    pend_next               = 1'b1;
                    scan_pos_next           = CW'(req.position);
                    scan_lim_next           = count_reg;
                    idx_next                = CW'(1);
                    scan_loc_next           = 1'b0;
                    case (req.opcode)
                        plc_pkg::OP_INSERT:
                        begin
                            if (!pos_insertable)
                                res_next.status = plc_pkg::ST_RANGE;
                            else if (full)
                                res_next.status = plc_pkg::ST_FULL;
                            else
                            begin
                                ctrl.ins   = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        plc_pkg::OP_DELETE:
                        begin
                            if (!pos_in_list)
                                res_next.status = plc_pkg::ST_RANGE;
                            else
                            begin
                                ctrl.del   = 1'b1;
                                count_next = count_reg - CW'(1);
                                pend_next  = 1'b0;
                                state_next = plc_pkg::S_SCAN;
                            end
                        end
                        plc_pkg::OP_GET:
                        begin
                            if (!pos_in_list)
                                res_next.status = plc_pkg::ST_RANGE;
                            else
                            begin
                                pend_next  = 1'b0;
                                state_next = plc_pkg::S_SCAN;
                            end
                        end
                        plc_pkg::OP_LOCATE:
                        begin
                            if (count_reg != '0)
                            begin
                                scan_loc_next = 1'b1;
                                pend_next     = 1'b0;
                                state_next    = plc_pkg::S_SCAN;
                            end
                        end
                        plc_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            // unused opcodes: plain ok result
                        end
                    endcase
                    res_next.length   = plc_pkg::POS_W'(count_next);
                    res_next.is_empty = (count_next == '0);
                end
            end
            plc_pkg::S_SCAN:
            begin
                // cell 0 of the tap chain holds the entry at position idx
                if (scan_loc_reg)
                begin
                    if (hit_w[0])
                    begin
                        res_next.found_position = plc_pkg::POS_W'(idx_reg);
                        pend_next  = 1'b1;
                        state_next = plc_pkg::S_IDLE;
                    end
                    else if (idx_reg == scan_lim_reg)
                    begin
                        pend_next  = 1'b1;
                        state_next = plc_pkg::S_IDLE;
                    end
                    else
                    begin
                        ctrl.shift = 1'b1;
                        idx_next   = idx_reg + CW'(1);
                    end
                end
                else
                begin
                    if (idx_reg == scan_pos_reg)
                    begin
                        res_next.data_out = tap_w[0];
                        pend_next  = 1'b1;
                        state_next = plc_pkg::S_IDLE;
                    end
                    else
                    begin
                        ctrl.shift = 1'b1;
                        idx_next   = idx_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = plc_pkg::S_IDLE;
            end
        endcase

        // output register: drop a taken item, load a pending one
        if (out_valid_reg && !rsp_stall)
            out_valid_next = 1'b0;
        if (pend_reg && (!out_valid_reg || !rsp_stall))
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
            pend_next      = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plc_pkg::S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        out_reg      <= out_next;
        scan_loc_reg <= scan_loc_next;
        scan_pos_reg <= scan_pos_next;
        scan_lim_reg <= scan_lim_next;
        idx_reg      <= idx_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

// ----- hdl/plc_cell.sv -----
// ---------------------------------------------------------------------------
// plc_cell: one list cell
// Holds one list entry and one tap-chain slot. The entry shifts with its
// neighbours on insert and delete; the tap slot carries a snapshot of the
// entry and its match flag towards the head of the chain during a scan.
// ---------------------------------------------------------------------------
`default_nettype none

module plc_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                       clk,
    input  wire plc_pkg::cell_ctrl_t        ctrl,
    input  wire logic [plc_pkg::DATA_W-1:0] left_entry,
    input  wire logic [plc_pkg::DATA_W-1:0] right_entry,
    input  wire logic [plc_pkg::DATA_W-1:0] right_tap,
    input  wire logic                       right_hit,
    output logic      [plc_pkg::DATA_W-1:0] entry,
    output logic      [plc_pkg::DATA_W-1:0] tap,
    output logic                            hit
);

    localparam logic [plc_pkg::POS_W-1:0] IDX = plc_pkg::POS_W'(INDEX);

    logic [plc_pkg::DATA_W-1:0] entry_reg;
    logic [plc_pkg::DATA_W-1:0] entry_next;
    logic [plc_pkg::DATA_W-1:0] tap_reg;
    logic [plc_pkg::DATA_W-1:0] tap_next;
    logic                       hit_reg;
    logic                       hit_next;

    // entry: take new value, left neighbour (insert) or right neighbour (delete)
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (IDX == ctrl.pos_m1)
                entry_next = ctrl.value;
            else if (IDX > ctrl.pos_m1)
                entry_next = left_entry;
        end
        else if (ctrl.del)
        begin
            if (IDX >= ctrl.pos_m1)
                entry_next = right_entry;
        end
    end

    // tap slot: snapshot on load, then follow the chain towards cell 0
    always_comb
    begin
        tap_next = tap_reg;
        hit_next = hit_reg;
        if (ctrl.load)
        begin
            tap_next = entry_reg;
            hit_next = (entry_reg == ctrl.value) && (IDX < ctrl.count);
        end
        else if (ctrl.shift)
        begin
            tap_next = right_tap;
            hit_next = right_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tap_reg   <= tap_next;
        hit_reg   <= hit_next;
    end

    assign entry = entry_reg;
    assign tap   = tap_reg;
    assign hit   = hit_reg;

endmodule

`default_nettype wire

// ----- hdl/plc_checker.sv -----
// ---------------------------------------------------------------------------
// plc_checker: port-level checks for the positional list engine
// Watches the result channel for stall hold, consistent length, flags, codes
// and found position.
`default_nettype none

module plc_checker #(
    parameter int DEPTH = 16
) (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire plc_pkg::rsp_t rsp
);

    // a stalled result item holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result item changed while stalled");

    // empty flag follows the length
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.is_empty == (rsp.length == '0)))
        else $error("is_empty disagrees with length");

    // length never beyond capacity
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.length <= plc_pkg::POS_W'(DEPTH)))
        else $error("length beyond list capacity");

    // only defined status codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == plc_pkg::ST_OK || rsp.status == plc_pkg::ST_RANGE
                       || rsp.status == plc_pkg::ST_FULL))
        else $error("undefined status code");

    // a located position lies within the list
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.found_position <= rsp.length))
        else $error("found position beyond length");

endmodule

bind positional_list_engine plc_checker #(.DEPTH(DEPTH)) u_plc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
